// ===== rtl/atrp_pkg.sv =====
package atrp_pkg;

   localparam int CFG_COUNT      = 6;
   localparam int CFG_IDX_W      = 3;
   localparam int WORD_W         = 16;
   localparam int CW             = 36;   // CORDIC datapath width
   localparam int ZW             = 32;   // angle accumulator, centidegrees * 2^16
   localparam int SQ_W           = 64;
   localparam int ROOT_W         = 32;
   localparam int MAX_STAGES     = 24;
   localparam int DEF_STAGES     = 16;
   localparam int Q15_HALF_SQRT2 = 23170;
   localparam int ROLL_LIMIT     = 18000;
   localparam int PITCH_LIMIT    = 9000;
   localparam int ROLL_W         = 16;
   localparam int PITCH_W        = 15;
   localparam logic signed [ZW-1:0] DEG90_Z = 32'sd589824000;

   typedef logic signed [WORD_W-1:0] atrp_word_type;

   typedef struct packed {
      logic                 ok;
      logic signed [CW-1:0] roll_y;
      logic signed [CW-1:0] roll_x;
      logic signed [CW-1:0] pitch_y;
   } atrp_side_type;

   function automatic logic signed [ZW-1:0] atan_entry(input int i);
      logic signed [ZW-1:0] v;
      case (i)
         0:  v = 32'sd294912000;
         1:  v = 32'sd174096719;
         2:  v = 32'sd91987925;
         3:  v = 32'sd46694507;
         4:  v = 32'sd23437865;
         5:  v = 32'sd11730358;
         6:  v = 32'sd5866610;
         7:  v = 32'sd2933484;
         8:  v = 32'sd1466764;
         9:  v = 32'sd733385;
         10: v = 32'sd366693;
         11: v = 32'sd183346;
         12: v = 32'sd91673;
         13: v = 32'sd45837;
         14: v = 32'sd22918;
         15: v = 32'sd11459;
         16: v = 32'sd5730;
         17: v = 32'sd2865;
         18: v = 32'sd1432;
         19: v = 32'sd716;
         20: v = 32'sd358;
         21: v = 32'sd179;
         22: v = 32'sd90;
         23: v = 32'sd45;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

// ===== rtl/atrp_front.sv =====
module atrp_front import atrp_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          en_i,
   input  logic          valid_i,
   input  atrp_word_type sample_i [CFG_COUNT],
   input  atrp_word_type bias_i   [CFG_COUNT],
   output logic          valid_o,
   output atrp_side_type side_o,
   output logic [SQ_W-1:0] sq_o
);

   logic signed [16:0] c_in [CFG_COUNT];
   logic               ok_in;

   logic signed [16:0] ca_ff [3];
   logic               oka_ff, va_ff;

   logic signed [17:0] s_in, d_in;
   logic signed [33:0] ps_in, pd_in;
   atrp_side_type      sb_in, sb_ff, sc_ff, sd_ff;
   logic               vb_ff, vc_ff, vd_ff;

   logic [31:0]        a1_in, a2_in;
   logic [SQ_W-1:0]    m1_ff, m2_ff, sq_ff;

   always_comb begin
      ok_in = 1'b1;
      for (int i = 0; i < CFG_COUNT; i++) begin
         c_in[i] = 17'(sample_i[i]) - 17'(bias_i[i]);
         if (c_in[i] == '0) ok_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
      end else if (en_i) begin
         va_ff <= valid_i;
      end
      if (en_i) begin
         for (int i = 0; i < 3; i++) ca_ff[i] <= c_in[i];
         oka_ff <= ok_in;
      end
   end

   // rotate 45 degrees: roll takes (-r1,-r2), pitch y is r0
   always_comb begin
      s_in  = 18'(ca_ff[1]) + 18'(ca_ff[2]);
      d_in  = 18'(ca_ff[1]) - 18'(ca_ff[2]);
      ps_in = 34'(s_in) * 34'sd23170;
      pd_in = 34'(d_in) * 34'sd23170;
      sb_in.ok      = oka_ff;
      sb_in.roll_y  = -(CW'(ca_ff[0]) <<< 15);
      sb_in.roll_x  = CW'(pd_in);
      sb_in.pitch_y = -CW'(ps_in);
   end

   always_comb begin
      a1_in = sb_ff.roll_y[CW-1] ? 32'(-sb_ff.roll_y) : 32'(sb_ff.roll_y);
      a2_in = sb_ff.roll_x[CW-1] ? 32'(-sb_ff.roll_x) : 32'(sb_ff.roll_x);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vb_ff <= 1'b0;
         vc_ff <= 1'b0;
         vd_ff <= 1'b0;
      end else if (en_i) begin
         vb_ff <= va_ff;
         vc_ff <= vb_ff;
         vd_ff <= vc_ff;
      end
      if (en_i) begin
         sb_ff <= sb_in;
         sc_ff <= sb_ff;
         m1_ff <= 64'(a1_in) * 64'(a1_in);
         m2_ff <= 64'(a2_in) * 64'(a2_in);
         sd_ff <= sc_ff;
         sq_ff <= m1_ff + m2_ff;
      end
   end

   assign valid_o = vd_ff;
   assign side_o  = sd_ff;
   assign sq_o    = sq_ff;

endmodule

// ===== rtl/atrp_isqrt.sv =====
module atrp_isqrt import atrp_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              en_i,
   input  logic              valid_i,
   input  atrp_side_type     side_i,
   input  logic [SQ_W-1:0]   sq_i,
   output logic              valid_o,
   output atrp_side_type     side_o,
   output logic [ROOT_W-1:0] root_o
);

   // one root bit per stage, most significant first
   logic [SQ_W+1:0]   rem_ff  [ROOT_W+1];
   logic [ROOT_W-1:0] q_ff    [ROOT_W+1];
   atrp_side_type     side_ff [ROOT_W+1];
   logic              v_ff    [ROOT_W+1];

   always_comb begin
      rem_ff[0]  = {2'b00, sq_i};
      q_ff[0]    = '0;
      side_ff[0] = side_i;
      v_ff[0]    = valid_i;
   end

   for (genvar k = 0; k < ROOT_W; k++) begin : g_bit
      localparam int B = ROOT_W - 1 - k;
      logic [SQ_W+1:0] test_in;
      assign test_in = ((SQ_W+2)'(q_ff[k]) << (B + 1)) + ((SQ_W+2)'(1) << (2 * B));

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k+1] <= 1'b0;
         end else if (en_i) begin
            v_ff[k+1] <= v_ff[k];
         end
         if (en_i) begin
            side_ff[k+1] <= side_ff[k];
            if (rem_ff[k] >= test_in) begin
               rem_ff[k+1] <= rem_ff[k] - test_in;
               q_ff[k+1]   <= q_ff[k] | (ROOT_W'(1) << B);
            end else begin
               rem_ff[k+1] <= rem_ff[k];
               q_ff[k+1]   <= q_ff[k];
            end
         end
      end
   end

   assign valid_o = v_ff[ROOT_W];
   assign side_o  = side_ff[ROOT_W];
   assign root_o  = q_ff[ROOT_W];

endmodule

// ===== rtl/atrp_cordic.sv =====
module atrp_cordic import atrp_pkg::*; #(
   parameter int STAGES = DEF_STAGES,
   parameter int LIMIT  = ROLL_LIMIT,
   parameter int OUT_W  = ROLL_W
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    en_i,
   input  logic                    valid_i,
   input  logic                    tag_i,
   input  logic signed [CW-1:0]    x_i,
   input  logic signed [CW-1:0]    y_i,
   output logic                    valid_o,
   output logic                    tag_o,
   output logic signed [OUT_W-1:0] angle_o
);

   localparam int N = (STAGES > MAX_STAGES) ? MAX_STAGES : STAGES;

   logic signed [CW-1:0] x_ff [N+1];
   logic signed [CW-1:0] y_ff [N+1];
   logic signed [ZW-1:0] z_ff [N+1];
   logic                 v_ff [N+1];
   logic                 t_ff [N+1];

   logic signed [CW-1:0] x0_in, y0_in;
   logic signed [ZW-1:0] z0_in;

   // quadrant pre-step
   always_comb begin
      x0_in = x_i;
      y0_in = y_i;
      z0_in = '0;
      if (x_i < 0) begin
         if (y_i >= 0) begin
            x0_in = y_i;
            y0_in = -x_i;
            z0_in = DEG90_Z;
         end else begin
            x0_in = -y_i;
            y0_in = x_i;
            z0_in = -DEG90_Z;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else if (en_i) begin
         v_ff[0] <= valid_i;
      end
      if (en_i) begin
         x_ff[0] <= x0_in;
         y_ff[0] <= y0_in;
         z_ff[0] <= z0_in;
         t_ff[0] <= tag_i;
      end
   end

   for (genvar i = 0; i < N; i++) begin : g_stage
      localparam logic signed [ZW-1:0] ATAN_I = atan_entry(i);
      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[i+1] <= 1'b0;
         end else if (en_i) begin
            v_ff[i+1] <= v_ff[i];
         end
         if (en_i) begin
            t_ff[i+1] <= t_ff[i];
            if (y_ff[i] >= 0) begin
               x_ff[i+1] <= x_ff[i] + (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] - (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] + ATAN_I;
            end else begin
               x_ff[i+1] <= x_ff[i] - (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] + (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] - ATAN_I;
            end
         end
      end
   end

   logic signed [ZW:0]   zr_in;
   logic signed [16:0]   a_in, sat_in;
   logic signed [OUT_W-1:0] angle_ff;
   logic                 vo_ff, to_ff;

   always_comb begin
      zr_in = (ZW+1)'(z_ff[N]) + (ZW+1)'(32768);
      a_in  = 17'(zr_in >>> 16);
      if (a_in > 17'sd0 + 17'(LIMIT)) sat_in = 17'(LIMIT);
      else if (a_in < -17'(LIMIT)) sat_in = -17'(LIMIT);
      else sat_in = a_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vo_ff <= 1'b0;
      end else if (en_i) begin
         vo_ff <= v_ff[N];
      end
      if (en_i) begin
         to_ff    <= t_ff[N];
         angle_ff <= sat_in[OUT_W-1:0];
      end
   end

   assign valid_o = vo_ff;
   assign tag_o   = to_ff;
   assign angle_o = angle_ff;

endmodule

// ===== rtl/accel_tilt_roll_pitch_unit.sv =====
// Tilt unit: roll and pitch, in centidegrees, from one IMU sample.
// Request channel req_*: six 16-bit axes (accel x,y,z then rate x,y,z)
// in req_tdata. Response channel rsp_*: rsp_tuser is sample_valid,
// rsp_tdata holds roll (16 bit) and pitch (15 bit); both zero when any
// bias-corrected axis is zero.
// Bias registers are written on csr_* (index 0..5, others ignored);
// the user must write them only while the unit is idle; the unit does not enforce it.
// Pipeline: 4 front stages (bias, 45-degree rotation, squares, sum),
// 32 square-root stages (one root bit each) and CORDIC_STAGES + 2
// CORDIC stages, roll and pitch side by side. It takes one request per
// cycle while the response channel is not stalled.
// The whole pipeline advances together: when rsp_tready is low with a
// response waiting, every stage holds and req_tready drops, so nothing
// is lost or repeated.
// Reset (synchronous) clears the biases and all stage valid bits.
module accel_tilt_roll_pitch_unit import atrp_pkg::*; #(
   parameter int CORDIC_STAGES = DEF_STAGES
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [95:0]          req_tdata,   // accel_x, accel_y, accel_z, rate_x, rate_y, rate_z
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [31:0]          rsp_tdata,   // roll_angle[15:0], pitch_angle[30:16], zero
   output logic                 rsp_tuser,   // sample_valid
   input  logic                 csr_wen,
   input  logic [CFG_IDX_W-1:0] csr_addr,
   input  logic [WORD_W-1:0]    csr_wdata
);

   atrp_word_type bias_ff [CFG_COUNT];
   atrp_word_type sample_in [CFG_COUNT];

   logic          en;
   logic          fv, sv, rv, rt;
   atrp_side_type fside, sside;
   logic [SQ_W-1:0]   fsq;
   logic [ROOT_W-1:0] root;
   logic signed [ROLL_W-1:0]  roll;
   logic signed [PITCH_W-1:0] pitch;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CFG_COUNT; i++) bias_ff[i] <= '0;
      end else if (csr_wen && (32'(csr_addr) < CFG_COUNT)) begin
         bias_ff[csr_addr] <= csr_wdata;
      end
   end

   always_comb begin
      for (int i = 0; i < CFG_COUNT; i++) sample_in[i] = req_tdata[16*i +: 16];
   end

   assign en         = !rsp_tvalid || rsp_tready;
   assign req_tready = en;

   atrp_front u_front (
      .clock, .reset, .en_i(en), .valid_i(req_tvalid),
      .sample_i(sample_in), .bias_i(bias_ff),
      .valid_o(fv), .side_o(fside), .sq_o(fsq)
   );

   atrp_isqrt u_isqrt (
      .clock, .reset, .en_i(en), .valid_i(fv), .side_i(fside), .sq_i(fsq),
      .valid_o(sv), .side_o(sside), .root_o(root)
   );

   atrp_cordic #(.STAGES(CORDIC_STAGES), .LIMIT(ROLL_LIMIT), .OUT_W(ROLL_W)) u_roll (
      .clock, .reset, .en_i(en), .valid_i(sv), .tag_i(sside.ok),
      .x_i(sside.roll_x), .y_i(sside.roll_y),
      .valid_o(rv), .tag_o(rt), .angle_o(roll)
   );

   atrp_cordic #(.STAGES(CORDIC_STAGES), .LIMIT(PITCH_LIMIT), .OUT_W(PITCH_W)) u_pitch (
      .clock, .reset, .en_i(en), .valid_i(sv), .tag_i(sside.ok),
      .x_i(CW'(root)), .y_i(sside.pitch_y),
      .valid_o(), .tag_o(), .angle_o(pitch)
   );

   assign rsp_tvalid = rv;
   assign rsp_tuser  = rt;
   assign rsp_tdata  = rt ? {1'b0, pitch, roll} : '0;

   a_ready : assert property (@(posedge clock) disable iff (reset)
      req_tready == (!rsp_tvalid || rsp_tready)) else $error("ready mismatch");
   a_inv_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser) |-> (rsp_tdata == '0)) else $error("invalid not zero");
   a_roll_rng : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |->
      ($signed(rsp_tdata[15:0]) <= 16'sd18000 && $signed(rsp_tdata[15:0]) >= -16'sd18000))
      else $error("roll out of range");
   a_stall : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> rsp_tvalid) else $error("response dropped");

endmodule

// ===== test/tilt_checker.sv =====
module tilt_checker import atrp_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   input  logic                 req_tready,
   input  logic [95:0]          req_tdata,
   input  logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   input  logic [31:0]          rsp_tdata,
   input  logic                 rsp_tuser,
   input  logic                 csr_wen,
   input  logic [CFG_IDX_W-1:0] csr_addr,
   input  logic [WORD_W-1:0]    csr_wdata,
   output int                   fail_count,
   output int                   pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic              valid;
      logic signed [15:0] roll;
      logic signed [14:0] pitch;
   } tilt_type;

   logic signed [15:0] bias [CFG_COUNT];
   tilt_type           tilt_q[$];

   function automatic longint shr_floor(longint v, int s);
      return v >>> s;
   endfunction

   function automatic longint root_floor(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return longint'(r);
   endfunction

   function automatic longint angle_of(longint y, longint x, longint lim);
      longint z, t, xs, ys;
      z = 0;
      if (x < 0) begin
         if (y >= 0) begin
            t = x; x = y; y = -t; z = longint'(DEG90_Z);
         end else begin
            t = x; x = -y; y = t; z = -longint'(DEG90_Z);
         end
      end
      for (int i = 0; i < DEF_STAGES; i++) begin
         xs = shr_floor(x, i);
         ys = shr_floor(y, i);
         if (y >= 0) begin
            x += ys; y -= xs; z += longint'(atan_entry(i));
         end else begin
            x -= ys; y += xs; z -= longint'(atan_entry(i));
         end
      end
      z = shr_floor(z + 32768, 16);
      if (z > lim) z = lim;
      if (z < -lim) z = -lim;
      return z;
   endfunction

   function automatic tilt_type tilt_of(logic [95:0] d);
      tilt_type res;
      longint c [6];
      longint r0, r1, r2, m1, m2;
      logic ok;
      ok = 1'b1;
      for (int i = 0; i < 6; i++) begin
         c[i] = longint'($signed(d[16*i +: 16])) - longint'(bias[i]);
         if (c[i] == 0) ok = 1'b0;
      end
      res.valid = ok;
      res.roll  = '0;
      res.pitch = '0;
      if (ok) begin
         r0 = -longint'(Q15_HALF_SQRT2) * (c[1] + c[2]);
         r1 = c[0] * 32768;
         r2 = -longint'(Q15_HALF_SQRT2) * (c[1] - c[2]);
         m1 = r1 < 0 ? -r1 : r1;
         m2 = r2 < 0 ? -r2 : r2;
         res.roll  = 16'(angle_of(-r1, -r2, ROLL_LIMIT));
         res.pitch = 15'(angle_of(r0, root_floor(longint'(m1*m1 + m2*m2)), PITCH_LIMIT));
      end
      return res;
   endfunction

   assign pending = tilt_q.size();

   always @(posedge clock) begin
      tilt_type e;
      if (reset) begin
         for (int i = 0; i < CFG_COUNT; i++) bias[i] <= '0;
         fail_count <= 0;
      end else begin
         if (csr_wen && csr_addr < CFG_COUNT) bias[csr_addr] <= csr_wdata;
         if (req_tvalid && req_tready) tilt_q.push_back(tilt_of(req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            if (tilt_q.size() == 0) begin
               if (fail_count < 10) $display("unexpected response %h", rsp_tdata);
               fail_count <= fail_count + 1;
            end else begin
               e = tilt_q.pop_front();
               if (rsp_tuser !== e.valid || rsp_tdata[15:0] !== e.roll
                     || rsp_tdata[30:16] !== e.pitch || rsp_tdata[31] !== 1'b0) begin
                  if (fail_count < 10)
                     $display("mismatch: exp v=%0d roll=%0d pitch=%0d, got v=%0d roll=%0d pitch=%0d",
                        e.valid, e.roll, e.pitch, rsp_tuser, $signed(rsp_tdata[15:0]),
                        $signed(rsp_tdata[30:16]));
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end
endmodule

// ===== test/tb.sv =====
module tb import atrp_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LATENCY = 38 + DEF_STAGES;
   localparam int DOG_LIMIT = 20000;

   logic                 clock, reset;
   logic                 req_tvalid, req_tready;
   logic [95:0]          req_tdata;
   logic                 rsp_tvalid, rsp_tready;
   logic [31:0]          rsp_tdata;
   logic                 rsp_tuser;
   logic                 csr_wen;
   logic [CFG_IDX_W-1:0] csr_addr;
   logic [WORD_W-1:0]    csr_wdata;
   int                   fail_count, pending, idle_cycles;
   logic                 stall_on;

   accel_tilt_roll_pitch_unit dut (.*);

   tilt_checker chk (.*);

   initial begin
      clock = 0;
      forever #1 clock = ~clock;
   end

   function automatic int gap_len();
      if ($urandom_range(0, 3) == 0) return 0;
      if ($urandom_range(0, 19) == 0) return $urandom_range(20, 80);
      return $urandom_range(0, 3);
   endfunction

   // receiver stalls, with stall-free stretches
   initial begin
      rsp_tready = 1'b0;
      stall_on = 1'b1;
      forever begin
         @(posedge clock);
         if ($urandom_range(0, 299) == 0) stall_on <= ~stall_on;
         rsp_tready <= !stall_on || ($urandom_range(0, 9) != 0 &&
            !($urandom_range(0, 99) == 0));
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= DOG_LIMIT) begin
         $display("** accel_tilt_roll_pitch_unit: FAILED **");
         $finish;
      end
   end

   // valid stays high after acceptance unless a gap follows
   task automatic send_sample(logic [95:0] d);
      int g;
      g = gap_len();
      if (g > 0) begin
         req_tvalid <= 1'b0;
         repeat (g) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= d;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   task automatic write_bias(int idx, logic [15:0] v);
      csr_wen   <= 1'b1;
      csr_addr  <= idx[CFG_IDX_W-1:0];
      csr_wdata <= v;
      @(posedge clock);
   endtask

   function automatic logic [15:0] axis_value(logic [15:0] b);
      case ($urandom_range(0, 9))
         0: return 16'h8000;
         1: return 16'h7fff;
         2: return b;
         3: return b + 16'($urandom_range(0, 2)) - 16'd1;
         4: return 16'($urandom_range(0, 8)) - 16'd4;
         default: return 16'($urandom());
      endcase
   endfunction

   task automatic random_phase(int n, logic [15:0] b [6]);
      logic [95:0] d;
      for (int k = 0; k < n; k++) begin
         for (int a = 0; a < 6; a++) d[16*a +: 16] = axis_value(b[a]);
         // mostly keep samples valid
         if ($urandom_range(0, 4) != 0)
            for (int a = 0; a < 6; a++)
               if (d[16*a +: 16] == b[a]) d[16*a +: 16] = b[a] + 16'd1;
         send_sample(d);
      end
   endtask

   initial begin
      logic [15:0] b [6];
      logic [95:0] d;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      csr_wen = 1'b0;
      csr_addr = '0;
      csr_wdata = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (b[i]) b[i] = '0;
      // directed: extremes, signs in every quadrant, zero axes
      send_sample({6{16'h8000}});
      send_sample({6{16'h7fff}});
      send_sample({6{16'h0001}});
      send_sample({6{16'hffff}});
      send_sample('0);
      send_sample({16'd1, 16'd1, 16'd1, 16'd1, 16'd1, 16'd0});
      send_sample({16'd1, 16'd1, 16'd0, 16'd1, 16'd1, 16'd1});
      for (int q = 0; q < 8; q++) begin
         d = {6{16'd7}};
         d[15:0]  = q[0] ? 16'h8000 : 16'h7fff;
         d[31:16] = q[1] ? 16'hc000 : 16'd123;
         d[47:32] = q[2] ? 16'hfff0 : 16'd5;
         send_sample(d);
      end
      send_sample({16'd3, 16'd3, 16'd3, 16'd100, 16'hff9c, 16'd1});
      send_sample({16'd3, 16'd3, 16'd3, 16'd100, 16'd100, 16'd1});
      random_phase(250, b);
      drain();
      // out-of-range index must be ignored
      write_bias(6, 16'h1234);
      write_bias(7, 16'h5678);
      for (int s = 0; s < 3; s++) begin
         for (int i = 0; i < 6; i++) begin
            case (s)
               0: b[i] = 16'h8000;
               1: b[i] = 16'h7fff;
               default: b[i] = 16'($urandom());
            endcase
            write_bias(i, b[i]);
         end
         csr_wen <= 1'b0;
         random_phase(200, b);
         drain();
      end
      drain();
      if (fail_count == 0)
         $display("** accel_tilt_roll_pitch_unit: PASSED **");
      else
         $display("** accel_tilt_roll_pitch_unit: FAILED **");
      $finish;
   end
endmodule

// ===== files.f =====
rtl/atrp_pkg.sv
rtl/atrp_front.sv
rtl/atrp_isqrt.sv
rtl/atrp_cordic.sv
rtl/accel_tilt_roll_pitch_unit.sv
test/tilt_checker.sv
test/tb.sv
